@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the allocator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/pfa_pkg.sv @@
package pfa_pkg;

   // Field widths fixed by the item layout.
   localparam int SIZE_W      = 16;
   localparam int TOTAL_W     = 20;
   localparam int OUT_IDX_W   = 3;
   localparam int IN_IDX_W    = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 4;
   localparam int POLICY_W    = 2;
   localparam int COUNT_W     = 4;

   localparam int DEFAULT_PARTITIONS = 8;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

   // Placement policies.
   localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT  = 2'd1;

   // Item modes.
   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_REQUEST = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

endpackage

@@ rtl/core/partition_fit_allocator_core.sv @@
// Fixed-partition allocator core.
// Input items arrive on the req_ ports and are taken at a clock edge where
// start is high and busy is low. A load item (req_mode 0) writes one
// partition size and clears the running leftover total; it finishes at once
// and its result strobes on rsp_valid in the next cycle.
// A request item (req_mode 1) scans the partitions in use with a single
// fit/compare unit, one partition per cycle, fed by a registered memory read.
// A request occupies the core through the scan, which runs through the
// memory read port and the one comparator, and through the update step. Busy
// stays high until the result is registered, and the result strobes for one
// cycle right after.
// Every item gives exactly one result, shown for one cycle only; the receiver
// cannot stall, and a new item may be started in the strobe cycle.
// Policy and partition count are written on the csr_ port, which is always
// ready and should only be written while the core is idle.
// Synchronous reset marks all partitions unavailable, clears the total and
// restores first fit with eight partitions.
`include "assert_macros.svh"

module partition_fit_allocator_core #(
   parameter int PARTITIONS = pfa_pkg::DEFAULT_PARTITIONS
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input item channel.
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_mode,
   input  logic [pfa_pkg::IN_IDX_W-1:0]    req_partition_index,
   input  logic [pfa_pkg::SIZE_W-1:0]      req_amount,
   // Result channel.
   output logic                            rsp_valid,
   output logic                            rsp_granted,
   output logic [pfa_pkg::OUT_IDX_W-1:0]   rsp_chosen_index,
   output logic [pfa_pkg::SIZE_W-1:0]      rsp_chosen_size,
   output logic [pfa_pkg::SIZE_W-1:0]      rsp_leftover,
   output logic [pfa_pkg::TOTAL_W-1:0]     rsp_total_leftover,
   // Configuration channel.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pfa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam int CNT_W = $clog2(PARTITIONS + 1);
   localparam logic [7:0] PART_LIM = 8'(PARTITIONS);

   // Partition sizes, with valid bits that reset clears.
   logic [pfa_pkg::SIZE_W-1:0] free_mem [PARTITIONS];
   logic [pfa_pkg::SIZE_W-1:0] mem_q_ff;

   pfa_pkg::state_type state_ff, state_in;
   logic [PARTITIONS-1:0]        valid_ff, valid_in;
   logic [pfa_pkg::TOTAL_W-1:0]  waste_ff, waste_in;
   logic [pfa_pkg::POLICY_W-1:0] policy_ff, policy_in;
   logic [pfa_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]             lim_ff, lim_in;
   logic [CNT_W-1:0]             iss_ff, iss_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic                         rd_ok_ff, rd_ok_in;
   logic [IDX_W-1:0]             rd_idx_ff, rd_idx_in;
   logic [pfa_pkg::SIZE_W-1:0]   amount_ff, amount_in;
   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             best_idx_ff, best_idx_in;
   logic [pfa_pkg::SIZE_W-1:0]   best_size_ff, best_size_in;

   logic                         granted_ff, granted_in;
   logic [pfa_pkg::OUT_IDX_W-1:0] chosen_idx_ff, chosen_idx_in;
   logic [pfa_pkg::SIZE_W-1:0]   chosen_size_ff, chosen_size_in;
   logic [pfa_pkg::SIZE_W-1:0]   leftover_ff, leftover_in;
   logic [pfa_pkg::TOTAL_W-1:0]  total_ff, total_in;

   logic                         accept;
   logic                         load_we;
   logic [7:0]                   load_wide;
   logic [IDX_W-1:0]             load_addr;
   logic [7:0]                   count_ext;
   logic [7:0]                   lim_wide;
   logic                         issue;
   logic [pfa_pkg::SIZE_W-1:0]   rd_size;
   logic                         fits;
   logic                         take;
   logic [pfa_pkg::SIZE_W-1:0]   left;
   logic [pfa_pkg::TOTAL_W:0]    sum_wide;
   logic [7:0]                   best_wide;
   logic                         grant_sane;

   assign accept    = start && (state_ff == pfa_pkg::ST_IDLE);
   assign busy      = (state_ff != pfa_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // Load address and range check.
   assign load_wide = {5'd0, req_partition_index};
   assign load_addr = load_wide[IDX_W-1:0];
   assign load_we   = accept && (req_mode == pfa_pkg::MODE_LOAD) && (load_wide < PART_LIM);

   // Scan length is the configured count, capped at the partition depth.
   assign count_ext = {4'd0, count_ff};
   assign lim_wide  = (count_ext > PART_LIM) ? PART_LIM : count_ext;

   assign issue = (state_ff == pfa_pkg::ST_SCAN) && (iss_ff < lim_ff);

   // Shared fit and ranking unit, working on the partition read last cycle.
   always_comb begin
      rd_size = rd_ok_ff ? mem_q_ff : '0;
      fits    = (rd_size != '0) && (rd_size >= amount_ff);
      take    = 1'b0;
      unique case (policy_ff)
         pfa_pkg::POL_FIRST: take = fits && !found_ff;
         pfa_pkg::POL_BEST:  take = fits && (!found_ff || (rd_size < best_size_ff));
         pfa_pkg::POL_WORST: take = fits && (!found_ff || (rd_size >= best_size_ff));
         default:            take = 1'b0;
      endcase
   end

   // Leftover and saturating total for the granted partition.
   assign left      = best_size_ff - amount_ff;
   assign sum_wide  = {1'b0, waste_ff} + {5'd0, left};
   assign best_wide = {{(8 - IDX_W){1'b0}}, best_idx_ff};

   // Sequencer and datapath next values.
   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      waste_in       = waste_ff;
      policy_in      = policy_ff;
      count_in       = count_ff;
      rsp_valid_in   = 1'b0;
      lim_in         = lim_ff;
      iss_in         = iss_ff;
      rd_vld_in      = 1'b0;
      rd_ok_in       = rd_ok_ff;
      rd_idx_in      = rd_idx_ff;
      amount_in      = amount_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_size_in   = best_size_ff;
      granted_in     = granted_ff;
      chosen_idx_in  = chosen_idx_ff;
      chosen_size_in = chosen_size_ff;
      leftover_in    = leftover_ff;
      total_in       = total_ff;

      // Configuration writes; indexes beyond the list are dropped.
      if (csr_valid) begin
         if (csr_index == pfa_pkg::CSR_POLICY) begin
            policy_in = csr_wdata[pfa_pkg::POLICY_W-1:0];
         end else if (csr_index == pfa_pkg::CSR_COUNT) begin
            count_in = csr_wdata;
         end
      end

      unique case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (accept) begin
               amount_in = req_amount;
               if (req_mode == pfa_pkg::MODE_LOAD) begin
                  if (load_we) begin
                     valid_in[load_addr] = 1'b1;
                  end
                  waste_in       = '0;
                  granted_in     = 1'b0;
                  chosen_idx_in  = '0;
                  chosen_size_in = '0;
                  leftover_in    = '0;
                  total_in       = '0;
                  rsp_valid_in   = 1'b1;
               end else begin
                  lim_in   = lim_wide[CNT_W-1:0];
                  iss_in   = '0;
                  found_in = 1'b0;
                  state_in = pfa_pkg::ST_SCAN;
               end
            end
         end
         pfa_pkg::ST_SCAN: begin
            // Issue one read per cycle and rank the one that came back.
            if (issue) begin
               rd_vld_in = 1'b1;
               rd_ok_in  = valid_ff[iss_ff[IDX_W-1:0]];
               rd_idx_in = iss_ff[IDX_W-1:0];
               iss_in    = iss_ff + 1'b1;
            end
            if (rd_vld_ff && take) begin
               found_in     = 1'b1;
               best_idx_in  = rd_idx_ff;
               best_size_in = rd_size;
            end
            if (!issue && !rd_vld_ff) begin
               state_in = pfa_pkg::ST_UPDATE;
            end
         end
         pfa_pkg::ST_UPDATE: begin
            if (found_ff) begin
               valid_in[best_idx_ff] = 1'b0;
               waste_in       = sum_wide[pfa_pkg::TOTAL_W] ? pfa_pkg::TOTAL_MAX
                                                           : sum_wide[pfa_pkg::TOTAL_W-1:0];
               granted_in     = 1'b1;
               chosen_idx_in  = best_wide[pfa_pkg::OUT_IDX_W-1:0];
               chosen_size_in = best_size_ff;
               leftover_in    = left;
               total_in       = sum_wide[pfa_pkg::TOTAL_W] ? pfa_pkg::TOTAL_MAX
                                                           : sum_wide[pfa_pkg::TOTAL_W-1:0];
            end else begin
               granted_in     = 1'b0;
               chosen_idx_in  = '0;
               chosen_size_in = '0;
               leftover_in    = '0;
               total_in       = waste_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = pfa_pkg::ST_IDLE;
         end
         default: state_in = pfa_pkg::ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfa_pkg::ST_IDLE;
         valid_ff     <= '0;
         waste_ff     <= '0;
         policy_ff    <= pfa_pkg::POL_FIRST;
         count_ff     <= pfa_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         waste_ff     <= waste_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lim_ff         <= lim_in;
      iss_ff         <= iss_in;
      rd_ok_ff       <= rd_ok_in;
      rd_idx_ff      <= rd_idx_in;
      amount_ff      <= amount_in;
      found_ff       <= found_in;
      best_idx_ff    <= best_idx_in;
      best_size_ff   <= best_size_in;
      granted_ff     <= granted_in;
      chosen_idx_ff  <= chosen_idx_in;
      chosen_size_ff <= chosen_size_in;
      leftover_ff    <= leftover_in;
      total_ff       <= total_in;
   end

   // Partition size memory: one write port for loads, one registered read.
   always_ff @(posedge clock) begin
      if (load_we) begin
         free_mem[load_addr] <= req_amount;
      end
      mem_q_ff <= free_mem[iss_ff[IDX_W-1:0]];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = granted_ff;
   assign rsp_chosen_index   = chosen_idx_ff;
   assign rsp_chosen_size    = chosen_size_ff;
   assign rsp_leftover       = leftover_ff;
   assign rsp_total_leftover = total_ff;

   // A granted result names a nonempty partition and a leftover within it.
   assign grant_sane = (rsp_chosen_size != '0) && (rsp_leftover <= rsp_chosen_size);

   // A request keeps the core busy; a load answers in the next cycle.
   `ASSERT_NEXT(a_req_busy, clock, reset, accept && req_mode, busy, "request did not start a scan")
   `ASSERT_NEXT(a_load_rsp, clock, reset, accept && !req_mode, rsp_valid, "load gave no result")
   // A compared read always lies inside the scan range.
   `ASSERT_IMP(a_rd_range, clock, reset, rd_vld_ff, CNT_W'(rd_idx_ff) < lim_ff, "read out of range")
   // A grant never reports an empty partition or a leftover beyond its size.
   `ASSERT_IMP(a_grant_ok, clock, reset, rsp_valid && rsp_granted, grant_sane, "bad grant")

endmodule
